@@ rtl/erseg_pkg.sv @@
`timescale 1ns / 1ps

package erseg_pkg;

   // Default geometry of the block.
   localparam int BLOCK_SIZE_DEF   = 4096;
   localparam int EXTENT_SLOTS_DEF = 8;

   // Fixed field widths.
   localparam int OFFSET_W   = 48;
   localparam int LENGTH_W   = 18;
   localparam int PHYS_W     = 40;
   localparam int COUNT_W    = 32;
   localparam int SLOT_IN_W  = 3;
   localparam int BOFF_OUT_W = 12;
   localparam int CHUNK_OUT_W = 13;

   // Upper bound on results for one read request.
   localparam int MAX_RESULTS = 64;
   localparam int RESULT_CNT_W = $clog2(MAX_RESULTS);

   // Register file: two registers at 8 byte spacing.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam logic REG_FILE_SIZE    = 1'b0;
   localparam logic REG_IS_DIRECTORY = 1'b1;

   // Transaction modes.
   localparam logic MODE_WRITE_EXTENT = 1'b0;
   localparam logic MODE_READ         = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNMAPPED  = 2'd1,
      STATUS_DIRECTORY = 2'd2
   } status_type;

   // One entry of the extent table.
   typedef struct packed {
      logic [PHYS_W-1:0]  start;
      logic [COUNT_W-1:0] count;
   } extent_type;

endpackage

@@ rtl/extent_read_segmenter.sv @@
`timescale 1ns / 1ps

// Extent map and read splitter for one file node. A mode 0 transaction writes one
// extent slot. A mode 1 transaction is a read request that is clamped to the file
// size and split into chunks that never cross a block boundary; each chunk is mapped
// to a physical block by walking the non-empty extents in slot order. The extent
// table lives in a single-port memory with a registered read, and that port paces
// the walk: each slot examined is first read, then compared, and a hit then sizes
// the chunk and loads it into the output register. A read request passes through
// set-up after acceptance (clamp, then start of the walk); a directory rejection
// skips both steps and an empty completion needs only the clamp, and each of these,
// like an unmapped block at the end of a walk, then loads its closing result from
// the done state. A new request is taken while the last result of the previous one
// still waits in the output register, but not before that result is loaded. At most
// 64 results are given for one request. The user must write the registers file_size
// (offset 0x0) and is_directory (offset 0x8) only while the block is idle; the block
// itself does not enforce this.
module extent_read_segmenter
   import erseg_pkg::*;
#(
   parameter int BLOCK_SIZE   = BLOCK_SIZE_DEF,
   parameter int EXTENT_SLOTS = EXTENT_SLOTS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_mode,
   input  logic [SLOT_IN_W-1:0]     req_extent_slot,
   input  logic [PHYS_W-1:0]        req_extent_start,
   input  logic [COUNT_W-1:0]       req_extent_blocks,
   input  logic [OFFSET_W-1:0]      req_request_offset,
   input  logic [LENGTH_W-1:0]      req_request_length,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [PHYS_W-1:0]        rsp_phys_block,
   output logic [BOFF_OUT_W-1:0]    rsp_block_offset,
   output logic [CHUNK_OUT_W-1:0]   rsp_chunk_length,
   output logic [1:0]               rsp_status,
   output logic                     rsp_last,

   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_W-1:0]    paddr,
   input  logic [CSR_DATA_W-1:0]    pwdata,
   output logic [CSR_DATA_W-1:0]    prdata,
   output logic                     pready
);

   localparam int BS_LOG = $clog2(BLOCK_SIZE);
   localparam int REM_W  = OFFSET_W - BS_LOG;
   localparam int CH_W   = BS_LOG + 1;
   localparam int SLOT_W = (EXTENT_SLOTS > 1) ? $clog2(EXTENT_SLOTS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_START,
      ST_READ,
      ST_CHECK,
      ST_SIZE,
      ST_EMIT,
      ST_DONE
   } state_type;

   // Configuration registers.
   logic [OFFSET_W-1:0]      file_size_ff;
   logic                     is_directory_ff;

   // Extent memory with one valid bit per slot.
   extent_type               ext_mem_ff [EXTENT_SLOTS];
   logic [EXTENT_SLOTS-1:0]  ext_valid_ff;
   extent_type               rd_data_ff;
   logic                     rd_valid_ff;

   // Request engine.
   state_type                state_ff;
   logic [OFFSET_W-1:0]      off_ff;
   logic [LENGTH_W-1:0]      len_ff;
   logic [OFFSET_W-1:0]      avail_ff;
   logic [LENGTH_W-1:0]      resid_ff;
   logic [REM_W-1:0]         rem_ff;
   logic [PHYS_W-1:0]        start_ff;
   logic [CH_W-1:0]          chunk_ff;
   logic [SLOT_W-1:0]        slot_ff;
   logic [RESULT_CNT_W-1:0]  result_cnt_ff;
   status_type               status_ff;

   // Output register.
   logic                     rsp_valid_ff;
   logic [PHYS_W-1:0]        rsp_phys_block_ff;
   logic [BOFF_OUT_W-1:0]    rsp_block_offset_ff;
   logic [CHUNK_OUT_W-1:0]   rsp_chunk_length_ff;
   status_type               rsp_status_ff;
   logic                     rsp_last_ff;

   logic                     req_fire;
   logic                     csr_write;
   logic                     out_free;
   logic                     rsp_load;
   logic [6:0]               slot_wide;
   logic                     slot_in_range;
   logic [SLOT_W-1:0]        wr_slot;
   logic [OFFSET_W:0]        avail_diff;
   logic [COUNT_W-1:0]       rd_count;
   logic [BS_LOG-1:0]        boff;
   logic [CH_W-1:0]          room;
   logic [OFFSET_W-1:0]      off_next;
   logic                     chunk_final;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = out_free && (state_ff == ST_EMIT || state_ff == ST_DONE);
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   // Register read-back.
   always_comb begin
      case (paddr[3])
         REG_FILE_SIZE:    prdata = CSR_DATA_W'(file_size_ff);
         REG_IS_DIRECTORY: prdata = CSR_DATA_W'(is_directory_ff);
         default:          prdata = '0;
      endcase
   end

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         file_size_ff    <= '0;
         is_directory_ff <= 1'b0;
      end else if (csr_write) begin
         case (paddr[3])
            REG_FILE_SIZE:    file_size_ff    <= pwdata[OFFSET_W-1:0];
            REG_IS_DIRECTORY: is_directory_ff <= pwdata[0];
            default:          ;
         endcase
      end
   end

   // Slots at or beyond the table depth are ignored.
   assign slot_wide     = {4'b0000, req_extent_slot};
   assign slot_in_range = (slot_wide < 7'(EXTENT_SLOTS));
   assign wr_slot       = slot_wide[SLOT_W-1:0];

   // Extent memory: written on an extent transaction, read during the walk.
   always_ff @(posedge clock) begin
      if (req_fire && req_mode == MODE_WRITE_EXTENT && slot_in_range) begin
         ext_mem_ff[wr_slot] <= '{start: req_extent_start, count: req_extent_blocks};
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= ext_mem_ff[slot_ff];
      end
   end

   // Valid bits make unwritten slots read as empty after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         ext_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (req_fire && req_mode == MODE_WRITE_EXTENT && slot_in_range) begin
            ext_valid_ff[wr_slot] <= 1'b1;
         end
         if (state_ff == ST_READ) begin
            rd_valid_ff <= ext_valid_ff[slot_ff];
         end
      end
   end

   // Datapath terms of the engine.
   assign avail_diff  = {1'b0, file_size_ff} - {1'b0, off_ff};
   assign rd_count    = rd_valid_ff ? rd_data_ff.count : '0;
   assign boff        = off_ff[BS_LOG-1:0];
   assign room        = CH_W'(BLOCK_SIZE) - {1'b0, boff};
   assign off_next    = off_ff + OFFSET_W'(chunk_ff);
   assign chunk_final = (resid_ff == LENGTH_W'(chunk_ff)) ||
                        (result_cnt_ff == RESULT_CNT_W'(MAX_RESULTS - 1));

   // Request sequencer and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_mode == MODE_READ) begin
                  off_ff <= req_request_offset;
                  len_ff <= req_request_length;
                  if (is_directory_ff) begin
                     status_ff <= STATUS_DIRECTORY;
                     state_ff  <= ST_DONE;
                  end else begin
                     state_ff <= ST_CLAMP;
                  end
               end
            end
            ST_CLAMP: begin
               // An offset at or past the end, or a zero length, gives an empty completion.
               avail_ff <= avail_diff[OFFSET_W-1:0];
               if (avail_diff[OFFSET_W] || avail_diff[OFFSET_W-1:0] == '0 || len_ff == '0) begin
                  status_ff <= STATUS_OK;
                  state_ff  <= ST_DONE;
               end else begin
                  state_ff <= ST_START;
               end
            end
            ST_START: begin
               resid_ff      <= (avail_ff > OFFSET_W'(len_ff)) ? len_ff
                                                                : avail_ff[LENGTH_W-1:0];
               rem_ff        <= off_ff[OFFSET_W-1:BS_LOG];
               slot_ff       <= '0;
               result_cnt_ff <= '0;
               state_ff      <= ST_READ;
            end
            ST_READ: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               // The remaining logical block either falls inside this extent or passes it.
               if (rem_ff < REM_W'(rd_count)) begin
                  start_ff <= rd_data_ff.start;
                  state_ff <= ST_SIZE;
               end else begin
                  rem_ff <= rem_ff - REM_W'(rd_count);
                  if (slot_ff == SLOT_W'(EXTENT_SLOTS - 1)) begin
                     status_ff <= STATUS_UNMAPPED;
                     state_ff  <= ST_DONE;
                  end else begin
                     slot_ff  <= slot_ff + 1'b1;
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_SIZE: begin
               chunk_ff <= (LENGTH_W'(room) > resid_ff) ? CH_W'(resid_ff) : room;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_phys_block_ff   <= start_ff + PHYS_W'(rem_ff);
                  rsp_block_offset_ff <= BOFF_OUT_W'(boff);
                  rsp_chunk_length_ff <= CHUNK_OUT_W'(chunk_ff);
                  rsp_status_ff       <= STATUS_OK;
                  rsp_last_ff         <= chunk_final;
                  resid_ff            <= resid_ff - LENGTH_W'(chunk_ff);
                  off_ff              <= off_next;
                  rem_ff              <= off_next[OFFSET_W-1:BS_LOG];
                  slot_ff             <= '0;
                  result_cnt_ff       <= result_cnt_ff + 1'b1;
                  state_ff            <= chunk_final ? ST_IDLE : ST_READ;
               end
            end
            ST_DONE: begin
               // Single closing result: rejection, empty completion or unmapped block.
               if (out_free) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_phys_block_ff   <= '0;
                  rsp_block_offset_ff <= '0;
                  rsp_chunk_length_ff <= '0;
                  rsp_status_ff       <= status_ff;
                  rsp_last_ff         <= 1'b1;
                  state_ff            <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_phys_block   = rsp_phys_block_ff;
   assign rsp_block_offset = rsp_block_offset_ff;
   assign rsp_chunk_length = rsp_chunk_length_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTHESIS
   // A chunk is never empty and never exceeds what is left of the request.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (chunk_ff != '0 && LENGTH_W'(chunk_ff) <= resid_ff))
      else $error("chunk length outside the remaining request");

   // A chunk stays inside one block.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> ((CH_W + 1)'(boff) + (CH_W + 1)'(chunk_ff)
                                 <= (CH_W + 1)'(BLOCK_SIZE)))
      else $error("chunk crosses a block boundary");

   // Loading a final result returns the engine to idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && chunk_final) |=> (state_ff == ST_IDLE && rsp_last_ff))
      else $error("final chunk did not close the request");
`endif

endmodule

@@ tb/extent_read_segmenter_checker.sv @@
`timescale 1ns / 1ps

module extent_read_segmenter_checker
   import erseg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_mode,
   input  logic [SLOT_IN_W-1:0]   req_extent_slot,
   input  logic [PHYS_W-1:0]      req_extent_start,
   input  logic [COUNT_W-1:0]     req_extent_blocks,
   input  logic [OFFSET_W-1:0]    req_request_offset,
   input  logic [LENGTH_W-1:0]    req_request_length,

   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [PHYS_W-1:0]      rsp_phys_block,
   input  logic [BOFF_OUT_W-1:0]  rsp_block_offset,
   input  logic [CHUNK_OUT_W-1:0] rsp_chunk_length,
   input  logic [1:0]             rsp_status,
   input  logic                   rsp_last,

   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic                   pready,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,

   output int                     mismatches,
   output int                     outstanding,
   output int                     results_checked
);

   localparam logic [63:0] BLOCK_BYTES = 64'(BLOCK_SIZE_DEF);
   localparam int          REPORT_LIMIT = 10;

   // One chunk of a read as the block should report it.
   typedef struct packed {
      logic [PHYS_W-1:0]      phys;
      logic [BOFF_OUT_W-1:0]  boff;
      logic [CHUNK_OUT_W-1:0] len;
      status_type             status;
      logic                   last;
   } segment_type;

   segment_type         expected_segments[$];
   logic [PHYS_W-1:0]   extent_base [EXTENT_SLOTS_DEF];
   logic [COUNT_W-1:0]  extent_len  [EXTENT_SLOTS_DEF];
   logic [OFFSET_W-1:0] file_bytes;
   logic                directory_node;
   int                  fail_total = 0;
   int                  seen_total = 0;

   function automatic void queue_segment(input logic [PHYS_W-1:0] phys,
                                         input logic [BOFF_OUT_W-1:0] boff,
                                         input logic [CHUNK_OUT_W-1:0] len,
                                         input status_type status,
                                         input logic last);
      expected_segments.push_back(segment_type'({phys, boff, len, status, last}));
   endfunction

   // Works out the chunks of one read request from the current extent map.
   function automatic void split_read(input logic [OFFSET_W-1:0] offset,
                                      input logic [LENGTH_W-1:0] length);
      logic [63:0]       pos;
      logic [63:0]       left;
      logic [63:0]       lblk;
      logic [63:0]       base;
      logic [63:0]       boff;
      logic [63:0]       take;
      logic [PHYS_W-1:0] phys;
      bit                hit;
      int                n;
      if (directory_node) begin
         queue_segment('0, '0, '0, STATUS_DIRECTORY, 1'b1);
         return;
      end
      pos  = 64'(offset);
      left = 64'(length);
      // Reads that start at or past the end, or ask for nothing, complete empty.
      if (pos >= 64'(file_bytes) || left == 0) begin
         queue_segment('0, '0, '0, STATUS_OK, 1'b1);
         return;
      end
      if (pos + left > 64'(file_bytes)) left = 64'(file_bytes) - pos;
      n = 0;
      while (left != 0 && n < MAX_RESULTS) begin
         // Walk the used slots in order, adding up their block counts.
         lblk = pos / BLOCK_BYTES;
         base = 0;
         hit  = 1'b0;
         phys = '0;
         for (int s = 0; s < EXTENT_SLOTS_DEF && !hit; s++) begin
            if (extent_len[s] != '0) begin
               if (lblk < base + 64'(extent_len[s])) begin
                  phys = extent_base[s] + PHYS_W'(lblk - base);
                  hit  = 1'b1;
               end else begin
                  base = base + 64'(extent_len[s]);
               end
            end
         end
         if (!hit) begin
            queue_segment('0, '0, '0, STATUS_UNMAPPED, 1'b1);
            return;
         end
         boff = pos % BLOCK_BYTES;
         take = BLOCK_BYTES - boff;
         if (take > left) take = left;
         left = left - take;
         pos  = pos + take;
         // The 64th chunk closes the request even when bytes remain.
         queue_segment(phys, BOFF_OUT_W'(boff), CHUNK_OUT_W'(take), STATUS_OK,
                       left == 0 || n == MAX_RESULTS - 1);
         n++;
      end
   endfunction

   // Compare results first, so that a transaction accepted in the same cycle
   // can never be matched against its own prediction.
   always @(posedge clock) begin
      segment_type want;
      segment_type got;
      if (reset) begin
         for (int s = 0; s < EXTENT_SLOTS_DEF; s++) begin
            extent_base[s] = '0;
            extent_len[s]  = '0;
         end
         file_bytes     = '0;
         directory_node = 1'b0;
         expected_segments.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = segment_type'({rsp_phys_block, rsp_block_offset, rsp_chunk_length,
                                 status_type'(rsp_status), rsp_last});
            seen_total++;
            if (expected_segments.size() == 0) begin
               fail_total++;
               if (fail_total <= REPORT_LIMIT)
                  $display({"Unexpected result %0d: phys %h offset %0d length %0d ",
                            "status %0d last %0b"},
                           seen_total, got.phys, got.boff, got.len, got.status, got.last);
            end else begin
               want = expected_segments.pop_front();
               if (want != got) begin
                  fail_total++;
                  if (fail_total <= REPORT_LIMIT) begin
                     $display("Mismatch on result %0d:", seen_total);
                     $display("  expected phys %h offset %0d length %0d status %0d last %0b",
                              want.phys, want.boff, want.len, want.status, want.last);
                     $display("  actual   phys %h offset %0d length %0d status %0d last %0b",
                              got.phys, got.boff, got.len, got.status, got.last);
                  end
               end
            end
         end

         if (req_valid && req_ready) begin
            if (req_mode == MODE_WRITE_EXTENT) begin
               if (req_extent_slot < EXTENT_SLOTS_DEF) begin
                  extent_base[req_extent_slot] = req_extent_start;
                  extent_len[req_extent_slot]  = req_extent_blocks;
               end
            end else begin
               split_read(req_request_offset, req_request_length);
            end
         end

         // Track register writes so the prediction follows the settings.
         if (psel && penable && pwrite && pready) begin
            if ((paddr >> 3) == CSR_ADDR_W'(REG_FILE_SIZE))
               file_bytes = pwdata[OFFSET_W-1:0];
            else if ((paddr >> 3) == CSR_ADDR_W'(REG_IS_DIRECTORY))
               directory_node = pwdata[0];
         end
      end
      outstanding     <= expected_segments.size();
      mismatches      <= fail_total;
      results_checked <= seen_total;
   end

endmodule

@@ tb/extent_read_segmenter_tb.sv @@
`timescale 1ns / 1ps

module extent_read_segmenter_tb
   import erseg_pkg::*;
();

   localparam int            CYCLE_LIMIT     = 20_000_000;
   localparam int            IDLE_CYCLES     = 40;
   localparam int            DRAIN_CYCLES    = 200;
   localparam int            RANDOM_PHASES   = 7;
   localparam int            ITEMS_PER_PHASE = 36;
   localparam logic [LENGTH_W-1:0] MAX_LENGTH = 18'd258048;
   localparam logic [63:0]   BLOCK_BYTES     = 64'(BLOCK_SIZE_DEF);
   localparam logic [63:0]   SIZE_MAX        = 64'hFFFF_FFFF_FFFF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_mode = MODE_WRITE_EXTENT;
   logic [SLOT_IN_W-1:0]   req_extent_slot = '0;
   logic [PHYS_W-1:0]      req_extent_start = '0;
   logic [COUNT_W-1:0]     req_extent_blocks = '0;
   logic [OFFSET_W-1:0]    req_request_offset = '0;
   logic [LENGTH_W-1:0]    req_request_length = '0;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [PHYS_W-1:0]      rsp_phys_block;
   logic [BOFF_OUT_W-1:0]  rsp_block_offset;
   logic [CHUNK_OUT_W-1:0] rsp_chunk_length;
   logic [1:0]             rsp_status;
   logic                   rsp_last;

   logic                   psel = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  paddr = '0;
   logic [CSR_DATA_W-1:0]  pwdata = '0;
   logic [CSR_DATA_W-1:0]  prdata;
   logic                   pready;

   int                     mismatches;
   int                     outstanding;
   int                     results_checked;

   int                     cycle_count = 0;
   int                     ready_hold = 0;
   int                     reads_sent = 0;
   int                     writes_sent = 0;
   int                     config_writes = 0;
   bit                     burst = 1'b0;
   logic [COUNT_W-1:0]     slot_blocks [EXTENT_SLOTS_DEF] = '{default: '0};

   extent_read_segmenter dut (.*);

   extent_read_segmenter_checker checker_inst (.*);

   always #1 clock = ~clock;

   // Guard against a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d results still outstanding.",
                  cycle_count, outstanding);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(0, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Read lengths lean towards a few blocks, with some full-size requests.
   function automatic logic [LENGTH_W-1:0] pick_length();
      int r;
      r = $urandom_range(0, 19);
      if (r < 11) return LENGTH_W'($urandom_range(1, 3 * BLOCK_SIZE_DEF));
      if (r < 14) return LENGTH_W'($urandom_range(0, BLOCK_SIZE_DEF));
      if (r < 18) return LENGTH_W'($urandom_range(0, MAX_LENGTH));
      return MAX_LENGTH;
   endfunction

   // The result side stalls at random, with occasional long stretches of readiness.
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (!rsp_ready) begin
         rsp_ready  <= 1'b1;
         ready_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : pick_gap();
      end else begin
         rsp_ready  <= 1'b0;
         ready_hold <= pick_gap();
      end
   end

   // Presents one transaction and returns at the edge where it is accepted.
   task automatic send_item(input logic mode, input logic [SLOT_IN_W-1:0] slot,
                            input logic [PHYS_W-1:0] start,
                            input logic [COUNT_W-1:0] blocks,
                            input logic [OFFSET_W-1:0] offset,
                            input logic [LENGTH_W-1:0] length);
      int gap;
      gap = burst ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_mode           <= mode;
      req_extent_slot    <= slot;
      req_extent_start   <= start;
      req_extent_blocks  <= blocks;
      req_request_offset <= offset;
      req_request_length <= length;
      req_valid          <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_write(input logic [SLOT_IN_W-1:0] slot, input logic [PHYS_W-1:0] start,
                             input logic [COUNT_W-1:0] blocks);
      logic [63:0] noise;
      noise = rand64();
      slot_blocks[slot] = blocks;
      writes_sent++;
      send_item(MODE_WRITE_EXTENT, slot, start, blocks, noise[OFFSET_W-1:0],
                LENGTH_W'($urandom_range(0, MAX_LENGTH)));
   endtask

   task automatic send_read(input logic [OFFSET_W-1:0] offset,
                            input logic [LENGTH_W-1:0] length);
      logic [63:0] noise;
      noise = rand64();
      reads_sent++;
      send_item(MODE_READ, SLOT_IN_W'($urandom_range(0, 7)), noise[PHYS_W-1:0], $urandom,
                offset, length);
   endtask

   // Stops sending and waits until every predicted result has come out.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the data at the access edge.
   task automatic csr_write(input logic index, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= CSR_ADDR_W'(index) << 3;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      config_writes++;
   endtask

   initial begin
      logic [PHYS_W-1:0]  starts [EXTENT_SLOTS_DEF];
      logic [COUNT_W-1:0] counts [EXTENT_SLOTS_DEF];
      logic [63:0]        span;
      logic [63:0]        lim;
      logic [63:0]        fsize;
      logic [63:0]        noise;
      int                 pick;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Straight out of reset the file is empty.
      send_read(48'd0, 18'd100);
      settle();
      fsize = SIZE_MAX;
      csr_write(REG_FILE_SIZE, fsize);
      // No extents yet, so the first block is unmapped.
      send_read(48'd0, 18'd10);
      send_write(3'd0, 40'hFF_FFFF_FFFE, 32'd4);
      send_write(3'd3, 40'h12_3456_7890, 32'd2);
      send_write(3'd5, 40'h00_0000_0000, 32'd57);
      // Zero length inside the file, then a read across a block boundary of the wrapping extent.
      send_read(48'd1234, 18'd0);
      send_read(48'd4095, 18'd2);
      // Long read that runs into the unmapped tail of the map.
      send_read(48'(3 * BLOCK_SIZE_DEF + 5), MAX_LENGTH);
      // Sixty-three mapped chunks, then the error as the last result.
      send_read(48'd5, MAX_LENGTH);
      send_write(3'd7, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
      // Now all sixty-four chunks map.
      send_read(48'd5, MAX_LENGTH);
      send_read(48'(64 * BLOCK_SIZE_DEF + 10), 18'd4100);
      send_read(48'hFFFF_FFFF_F000, 18'd4096);
      send_read(48'hFFFF_FFFF_FFFF, 18'd1);
      send_write(3'd1, 40'h00_0000_0000, 32'd0);
      settle();
      // Directory node: every read is refused, extent writes still land.
      csr_write(REG_IS_DIRECTORY, 64'd1);
      send_read(48'd0, 18'd100);
      send_write(3'd6, 40'hAA_5555_AAAA, 32'd0);
      send_read(48'hFFFF_FFFF_FFFF, MAX_LENGTH);
      settle();
      csr_write(REG_IS_DIRECTORY, 64'd0);
      // Short file: reads are clamped at its end.
      fsize = 64'(3 * BLOCK_SIZE_DEF + 100);
      csr_write(REG_FILE_SIZE, fsize);
      send_read(48'(2 * BLOCK_SIZE_DEF + 50), 18'd5000);
      send_read(48'(fsize), 18'd10);
      send_read(48'(fsize - 1), MAX_LENGTH);
      settle();
      fsize = 64'd0;
      csr_write(REG_FILE_SIZE, fsize);
      send_read(48'd0, 18'd1);

      // Random phases: a fresh extent map and settings, then mostly sensible reads.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         span = 0;
         for (int s = 0; s < EXTENT_SLOTS_DEF; s++) begin
            pick = $urandom_range(0, 7);
            if (pick == 0) counts[s] = '0;
            else if (pick == 1) counts[s] = $urandom;
            else counts[s] = $urandom_range(1, 12);
            noise = rand64();
            if ($urandom_range(0, 5) == 0)
               starts[s] = 40'hFF_FFFF_FFFF - $urandom_range(0, 20);
            else
               starts[s] = noise[PHYS_W-1:0];
            span = span + 64'(counts[s]);
         end
         case ($urandom_range(0, 5))
            0: fsize = SIZE_MAX;
            1: fsize = (span == 0) ? SIZE_MAX : span * BLOCK_BYTES - $urandom_range(0, 4095);
            2, 3: fsize = span * BLOCK_BYTES + $urandom_range(0, 8192);
            4: fsize = rand64();
            default: fsize = 64'($urandom_range(0, 20000));
         endcase
         fsize = fsize & SIZE_MAX;
         settle();
         csr_write(REG_FILE_SIZE, fsize);
         csr_write(REG_IS_DIRECTORY, 64'($urandom_range(0, 6) == 0));
         burst = ($urandom_range(0, 3) == 0);
         for (int s = 0; s < EXTENT_SLOTS_DEF; s++)
            send_write(SLOT_IN_W'(s), starts[s], counts[s]);

         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            // Now and then hold off until the block has drained.
            if ($urandom_range(0, 29) == 0) settle();
            pick  = $urandom_range(0, 19);
            noise = rand64();
            if (pick < 2) begin
               send_write(SLOT_IN_W'($urandom_range(0, 7)), noise[PHYS_W-1:0],
                          ($urandom_range(0, 1) == 0) ? $urandom_range(0, 12) : $urandom);
            end else if (pick == 2) begin
               send_read(noise[OFFSET_W-1:0], LENGTH_W'($urandom_range(0, MAX_LENGTH)));
            end else if (pick == 3) begin
               send_read(OFFSET_W'(fsize - $urandom_range(0, 8)), pick_length());
            end else begin
               // Aim inside the mapped part of the file, a little past it at most.
               span = 0;
               for (int s = 0; s < EXTENT_SLOTS_DEF; s++) span = span + 64'(slot_blocks[s]);
               lim = span * BLOCK_BYTES;
               if (lim > fsize) lim = fsize;
               lim = lim + 2 * BLOCK_BYTES;
               send_read(OFFSET_W'(noise % (lim + 1)), pick_length());
            end
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d read requests and %0d extent writes across %0d register writes.",
               reads_sent, writes_sent, config_writes);
      $display("Checked %0d results, %0d of them wrong or unexpected.",
               results_checked, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ extent_read_segmenter.f @@
rtl/erseg_pkg.sv
rtl/extent_read_segmenter.sv
tb/extent_read_segmenter_checker.sv
tb/extent_read_segmenter_tb.sv
